### hdl/lcdsf_pkg.sv
// Package for the LCD serial command framer.
// Holds transaction types, opcodes, framing constants and defaults.
// No dependencies.
package lcdsf_pkg;

  localparam int DEF_BYTES_PER_LINE = 16;
  localparam int DEF_PIXEL_LINES    = 64;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [1:0] OP_CMD    = 2'd0;
  localparam logic [1:0] OP_DATA   = 2'd1;
  localparam logic [1:0] OP_LOCATE = 2'd2;
  localparam logic [1:0] OP_FRAME  = 2'd3;

  localparam logic [7:0] SYNC_CMD   = 8'hF8;
  localparam logic [7:0] SYNC_DATA  = 8'hFA;
  localparam logic [7:0] HI_MASK    = 8'hF0;
  localparam logic [7:0] LO_MASK    = 8'h0F;
  localparam logic [7:0] CMD_EXT    = 8'h34;
  localparam logic [7:0] CMD_BASIC  = 8'h30;
  localparam logic [7:0] CMD_GFX_ON = 8'h36;
  localparam logic [7:0] ADDR_BASE  = 8'h80;
  localparam logic [7:0] XA_LOWER   = 8'h80;
  localparam logic [7:0] XA_UPPER   = 8'h88;
  localparam logic [7:0] HALF_LINES = 8'd32;

  localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'h90, 8'h88, 8'h98};

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] value;
    logic [1:0] row;
    logic [2:0] column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] serial_byte;
    logic       last_byte;
  } out_item_t;

  // One classified transaction handed from front to back.
  typedef struct packed {
    logic       hdr;
    logic       trl;
    logic       is_data;
    logic [7:0] value;
    logic [7:0] ya;
    logic [7:0] xa;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### hdl/lcd_serial_command_framer_top.sv
// Top level of the LCD serial command framer.
// Instantiates lcdsf_front, lcdsf_queue and lcdsf_back. Uses lcdsf_pkg.
//
//   Channel   Direction  Handshake            Payload
//   in_       input      in_valid / in_stall  in_item  (in_item_t)
//   out_      output     out_valid/out_stall  out_item (out_item_t)
//
// One serial byte leaves per cycle while out_stall is low: 3 bytes per item,
// 15 for a frame byte that starts a line, 9 for the last byte of a frame.
// The back-end sequencer sets that rate; the 4-entry job queue absorbs bursts.
// Input is accepted whenever the queue has room, also while output stalls.
// rst_n is synchronous; it empties the queue and returns the frame position
// to line 0, byte 0.
module lcd_serial_command_framer_top #(
  parameter int BYTES_PER_LINE = lcdsf_pkg::DEF_BYTES_PER_LINE,
  parameter int PIXEL_LINES    = lcdsf_pkg::DEF_PIXEL_LINES,
  parameter int QUEUE_DEPTH    = lcdsf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcdsf_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdsf_pkg::out_item_t out_item
);
  import lcdsf_pkg::*;

  job_t      push_job, head;
  q_status_t q_stat;
  logic      push, pop, head_valid;

  lcdsf_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE),
    .PIXEL_LINES   (PIXEL_LINES)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item (in_item),
    .q_stat  (q_stat),
    .push    (push),
    .push_job(push_job)
  );

  lcdsf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .head      (head),
    .head_valid(head_valid),
    .q_stat    (q_stat)
  );

  lcdsf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(head_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### hdl/lcdsf_front.sv
// Front end: accepts input transactions and classifies them into jobs.
// Keeps the framebuffer line and byte position. Uses lcdsf_pkg.
module lcdsf_front #(
  parameter int BYTES_PER_LINE = lcdsf_pkg::DEF_BYTES_PER_LINE,
  parameter int PIXEL_LINES    = lcdsf_pkg::DEF_PIXEL_LINES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcdsf_pkg::in_item_t in_item,
  input  lcdsf_pkg::q_status_t q_stat,
  output logic                push,
  output lcdsf_pkg::job_t     push_job
);
  import lcdsf_pkg::*;

  localparam int COL_W  = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
  localparam int LINE_W = $clog2(PIXEL_LINES);

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic              accept, col_end, frame_end;
  logic [7:0]        line_ext, line_off;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign push      = accept;
  assign col_end   = (col_r == COL_W'(BYTES_PER_LINE - 1));
  assign frame_end = col_end && (line_r == LINE_W'(PIXEL_LINES - 1));
  assign line_ext  = 8'(line_r);
  assign line_off  = (line_ext < HALF_LINES) ? line_ext : (line_ext - HALF_LINES);

  always_comb begin
    push_job         = '0;
    push_job.value   = in_item.value;
    push_job.ya      = ADDR_BASE + line_off;
    push_job.xa      = (line_ext < HALF_LINES) ? XA_LOWER : XA_UPPER;
    case (in_item.opcode)
      OP_CMD: begin
        push_job.is_data = 1'b0;
      end
      OP_DATA: begin
        push_job.is_data = 1'b1;
      end
      OP_LOCATE: begin
        push_job.value = ROW_BASE[in_item.row] | 8'(in_item.column);
      end
      OP_FRAME: begin
        push_job.is_data = 1'b1;
        push_job.hdr     = (col_r == '0);
        // Result cap drops the trailer when header and trailer coincide.
        push_job.trl     = frame_end && (col_r != '0);
      end
      default: begin
        push_job.is_data = 1'b0;
      end
    endcase
  end

  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (accept && (in_item.opcode == OP_FRAME)) begin
      if (frame_end) begin
        col_nxt  = '0;
        line_nxt = '0;
      end else if (col_end) begin
        col_nxt  = '0;
        line_nxt = line_r + 1'b1;
      end else begin
        col_nxt  = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

### hdl/lcdsf_queue.sv
// Short job queue between front and back ends.
// Register array with read and write pointers. Uses lcdsf_pkg.
module lcdsf_queue #(
  parameter int DEPTH = lcdsf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcdsf_pkg::job_t      push_job,
  input  logic                 pop,
  output lcdsf_pkg::job_t      head,
  output logic                 head_valid,
  output lcdsf_pkg::q_status_t q_stat
);
  import lcdsf_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (AW+1)'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign head_valid   = !q_stat.empty;
  assign head         = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

### hdl/lcdsf_back.sv
// Back end: expands each job into framed serial bytes, one per cycle while out_stall is low.
// Slot sequencer plus output register. Uses lcdsf_pkg.
module lcdsf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdsf_pkg::job_t      head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcdsf_pkg::out_item_t out_item
);
  import lcdsf_pkg::*;

  localparam logic [1:0] PH_SYNC = 2'd0;
  localparam logic [1:0] PH_HI   = 2'd1;
  localparam logic [1:0] PH_LO   = 2'd2;

  localparam logic [2:0] SLOT_EXT   = 3'd0;
  localparam logic [2:0] SLOT_YA    = 3'd1;
  localparam logic [2:0] SLOT_XA    = 3'd2;
  localparam logic [2:0] SLOT_BASIC = 3'd3;
  localparam logic [2:0] SLOT_MAIN  = 3'd4;
  localparam logic [2:0] SLOT_TEXT  = 3'd5;
  localparam logic [2:0] SLOT_GFX   = 3'd6;

  logic [1:0] phase_r, phase_nxt;
  logic [2:0] slot_r, slot_nxt, cur_slot, end_slot;
  logic       active_r, active_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       advance, fire, final_b;
  logic [7:0] cmd_byte, sync_byte, ser_byte;

  assign advance  = !out_valid_r || !out_stall;
  assign fire     = advance && head_valid;
  assign cur_slot = active_r ? slot_r : (head.hdr ? SLOT_EXT : SLOT_MAIN);
  assign end_slot = head.trl ? SLOT_GFX : SLOT_MAIN;
  assign final_b  = (phase_r == PH_LO) && (cur_slot == end_slot);
  assign pop      = fire && final_b;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    sync_byte = SYNC_CMD;
    case (cur_slot)
      SLOT_EXT:   cmd_byte = CMD_EXT;
      SLOT_YA:    cmd_byte = head.ya;
      SLOT_XA:    cmd_byte = head.xa;
      SLOT_BASIC: cmd_byte = CMD_BASIC;
      SLOT_MAIN: begin
        cmd_byte  = head.value;
        sync_byte = head.is_data ? SYNC_DATA : SYNC_CMD;
      end
      SLOT_TEXT:  cmd_byte = CMD_EXT;
      SLOT_GFX:   cmd_byte = CMD_GFX_ON;
      default:    cmd_byte = CMD_BASIC;
    endcase
  end

  always_comb begin
    case (phase_r)
      PH_SYNC: ser_byte = sync_byte;
      PH_HI:   ser_byte = cmd_byte & HI_MASK;
      PH_LO:   ser_byte = (cmd_byte & LO_MASK) << 4;
      default: ser_byte = sync_byte;
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    slot_nxt      = slot_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (fire) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.serial_byte = ser_byte;
      out_item_nxt.last_byte   = final_b;
      if (phase_r == PH_LO) begin
        phase_nxt  = PH_SYNC;
        slot_nxt   = cur_slot + 1'b1;
        active_nxt = !final_b;
      end else begin
        phase_nxt  = phase_r + 1'b1;
        slot_nxt   = cur_slot;
        active_nxt = 1'b1;
      end
    end else if (advance) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SYNC;
      slot_r      <= SLOT_MAIN;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      slot_r      <= slot_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/lcdsf_checker.sv
// Port-level checker for the LCD serial command framer, bound to the top.
// Uses lcdsf_pkg.
module lcdsf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input lcdsf_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input lcdsf_pkg::out_item_t out_item
);
  import lcdsf_pkg::*;

  logic       in_acc, out_acc;
  logic [7:0] pend_r, pend_nxt;
  logic [3:0] run_r;
  logic [1:0] tri_r;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !(out_acc && out_item.last_byte)) begin
      pend_nxt = pend_r + 1'b1;
    end else if (!in_acc && out_acc && out_item.last_byte) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      run_r  <= '0;
      tri_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      if (out_acc) begin
        run_r <= out_item.last_byte ? 4'd0 : run_r + 1'b1;
        tri_r <= (out_item.last_byte || tri_r == 2'd2) ? 2'd0 : tri_r + 1'b1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output transaction changed");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 8'd0)
    else $error("output transaction without pending input");

  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> run_r < 4'd15)
    else $error("more than fifteen bytes for one input");

  a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && tri_r == 2'd0 |->
      out_item.serial_byte == SYNC_CMD || out_item.serial_byte == SYNC_DATA)
    else $error("framed group does not open with a sync byte");

endmodule

bind lcd_serial_command_framer_top lcdsf_checker u_lcdsf_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_item  (in_item),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_item (out_item)
);

### sim/tb_lcd_serial_command_framer_top.sv
// Testbench for lcd_serial_command_framer_top: drives commands, data, locates and
// framebuffer bytes, predicts every serial byte and checks each output transaction.
// Depends on lcdsf_pkg and the framer RTL.
`timescale 1ns / 1ps

module tb_lcd_serial_command_framer_top;
  import lcdsf_pkg::*;

  localparam int BPL          = DEF_BYTES_PER_LINE;
  localparam int LINES        = DEF_PIXEL_LINES;
  localparam int FRAME_BYTES  = BPL * LINES;
  localparam int MAX_BYTES    = 15;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int MIX_ITEMS    = 100;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  out_item_t   serial_expected[$];
  out_item_t   item_bytes[MAX_BYTES];
  int          item_byte_count;
  int unsigned frame_pos;
  int          err_count;
  int unsigned cycle_count;
  int          burst_left;
  bit          no_gaps;
  int          hold_seq;

  lcd_serial_command_framer_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function void add_byte(logic [7:0] b);
    if (item_byte_count < MAX_BYTES) begin
      item_bytes[item_byte_count].serial_byte = b;
      item_bytes[item_byte_count].last_byte   = 1'b0;
      item_byte_count++;
    end
  endfunction

  function void add_framed(logic [7:0] sync, logic [7:0] v);
    add_byte(sync);
    add_byte(v & HI_MASK);
    add_byte({v[3:0], 4'h0});
  endfunction

  function void expand_command(in_item_t it);
    int unsigned pos;
    int          line_no;
    logic [7:0]  xa;
    logic [7:0]  ya;
    bit          last_in_frame;
    item_byte_count = 0;
    case (it.opcode)
      OP_CMD:    add_framed(SYNC_CMD, it.value);
      OP_DATA:   add_framed(SYNC_DATA, it.value);
      OP_LOCATE: add_framed(SYNC_CMD, ROW_BASE[it.row] | {5'b0, it.column});
      default: begin
        last_in_frame = (frame_pos + 1 >= FRAME_BYTES);
        pos = frame_pos;
        if (pos >= FRAME_BYTES) pos = FRAME_BYTES - 1;
        if (pos % BPL == 0) begin
          line_no = pos / BPL;
          if (line_no < int'(HALF_LINES)) begin
            xa = XA_LOWER;
            ya = 8'(int'(ADDR_BASE) + line_no);
          end else begin
            xa = XA_UPPER;
            ya = 8'(int'(ADDR_BASE) + line_no - int'(HALF_LINES));
          end
          add_framed(SYNC_CMD, CMD_EXT);
          add_framed(SYNC_CMD, ya);
          add_framed(SYNC_CMD, xa);
          add_framed(SYNC_CMD, CMD_BASIC);
        end
        add_framed(SYNC_DATA, it.value);
        if (last_in_frame) begin
          add_framed(SYNC_CMD, CMD_EXT);
          add_framed(SYNC_CMD, CMD_GFX_ON);
          frame_pos = 0;
        end else begin
          frame_pos = pos + 1;
        end
      end
    endcase
    if (item_byte_count > 0) item_bytes[item_byte_count - 1].last_byte = 1'b1;
    for (int i = 0; i < item_byte_count; i++) serial_expected.push_back(item_bytes[i]);
  endfunction

  function in_item_t make_item(logic [1:0] op, logic [7:0] v, logic [1:0] r, logic [2:0] c);
    in_item_t it;
    it.opcode = op;
    it.value  = v;
    it.row    = r;
    it.column = c;
    return it;
  endfunction

  function in_item_t random_item(int frame_pct);
    logic [1:0] op;
    if ($urandom_range(0, 99) < frame_pct) op = OP_FRAME;
    else op = 2'($urandom_range(0, 2));
    return make_item(op, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                     3'($urandom_range(0, 7)));
  endfunction

  // Call at a rising edge; returns at the edge where the transaction is accepted, or after a random idle gap.
  task send_item(in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expand_command(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: switch among four stall patterns at random; hold off on request.
  always @(posedge clk) begin : rx_stall
    int unsigned rx_cycle;
    int          stall_mode;
    int          hold_left;
    int          hold_seen;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cycle  = 0;
      stall_mode = 0;
      hold_left = 0;
      hold_seen = hold_seq;
    end else begin
      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (rx_cycle % 8 < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : out_check
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_lcd_serial_command_framer_top: done, errors");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      if (serial_expected.size() == 0) begin
        $error("serial_byte: expected none, actual %02h", out_item.serial_byte);
        err_count++;
      end else begin
        want = serial_expected.pop_front();
        if (out_item.serial_byte !== want.serial_byte) begin
          $error("serial_byte: expected %02h, actual %02h", want.serial_byte,
                 out_item.serial_byte);
          err_count++;
        end
        if (out_item.last_byte !== want.last_byte) begin
          $error("last_byte: expected %0b, actual %0b", want.last_byte, out_item.last_byte);
          err_count++;
        end
      end
    end
  end

  task test_directed_ops();
    no_gaps = 1'b1;
    send_item(make_item(OP_FRAME, 8'h00, 2'd0, 3'd0));
    send_item(make_item(OP_CMD, 8'h00, 2'd0, 3'd0));
    send_item(make_item(OP_CMD, 8'hFF, 2'd3, 3'd7));
    send_item(make_item(OP_CMD, 8'hA5, 2'd1, 3'd2));
    send_item(make_item(OP_DATA, 8'h00, 2'd0, 3'd0));
    send_item(make_item(OP_DATA, 8'hFF, 2'd3, 3'd7));
    send_item(make_item(OP_DATA, 8'h5A, 2'd2, 3'd5));
    for (int r = 0; r < 4; r++) begin
      send_item(make_item(OP_LOCATE, 8'hFF, 2'(r), 3'd0));
      send_item(make_item(OP_LOCATE, 8'h00, 2'(r), 3'd7));
    end
    send_item(make_item(OP_FRAME, 8'hFF, 2'd3, 3'd7));
    send_item(make_item(OP_FRAME, 8'h81, 2'd1, 3'd3));
    no_gaps = 1'b0;
  endtask

  task test_random_mix();
    for (int i = 0; i < MIX_ITEMS; i++) send_item(random_item(40));
  endtask

  // Hold the output for a long stretch while input keeps coming back to back.
  task test_backpressure();
    no_gaps = 1'b1;
    hold_seq++;
    for (int i = 0; i < 24; i++) send_item(random_item(50));
    no_gaps = 1'b0;
  endtask

  initial begin
    err_count      = 0;
    cycle_count    = 0;
    frame_pos      = 0;
    burst_left     = 0;
    no_gaps        = 1'b0;
    hold_seq       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_random_mix();
    test_backpressure();
    test_random_mix();
    in_valid <= 1'b0;
    while (serial_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_lcd_serial_command_framer_top: done, clean");
    end else begin
      $display("tb_lcd_serial_command_framer_top: done, errors");
    end
    $finish;
  end

endmodule
